// ===== design/encpid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package encpid_pkg;

	// Encoder and fixed-point format
	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int GAIN_FRAC  = 8;

	// Field widths
	localparam int TARGET_W = 10;
	localparam int GAIN_W   = 16;
	localparam int DRIVE_W  = 10;
	localparam int DUTY_W   = 10;
	localparam int SPEED_W  = 26;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Speed scaling: |delta| * 10240 / 13 is done as |delta| * SPEED_RECIP >> SPEED_SHIFT.
	// The reciprocal is rounded up and exact for every 17-bit magnitude.
	localparam int SPEED_MAG_W  = COUNT_BITS + 1;
	localparam int SPEED_SHIFT  = 20;
	localparam int SPEED_RECIP_W = 30;
	localparam logic [SPEED_RECIP_W-1:0] SPEED_RECIP = 30'd825955250;
	localparam int SPEED_PROD_W = SPEED_MAG_W + SPEED_RECIP_W;
	localparam int SPEED_QMAG_W = SPEED_W - 1;

	// Error and its division by the tick rate (20 = 4 * 5)
	localparam int ERR_W     = 27;
	localparam int ERR_MAG_W = 25;
	localparam int QTR_W     = ERR_MAG_W - 2;
	localparam int DIV5_SHIFT = 26;
	localparam int DIV5_RECIP_W = 24;
	localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 24'd13421773;
	localparam int DIV5_PROD_W = QTR_W + DIV5_RECIP_W;
	localparam int STEP_MAG_W  = 21;

	// Controller state and products
	localparam int INTEG_W = 32;
	localparam int DIFF_W  = 28;
	localparam int DERIV_W = 32;
	localparam int PROP_PROD_W  = GAIN_W + ERR_W;
	localparam int INTEG_PROD_W = GAIN_W + INTEG_W;
	localparam int DERIV_PROD_W = GAIN_W + DERIV_W;
	localparam int SUM_W = 50;
	localparam int DRIVE_SHIFT = FRAC_BITS + GAIN_FRAC;
	localparam int DRIVE_Q_W   = SUM_W - DRIVE_SHIFT;

	localparam int DRIVE_LIMIT  = 500;
	localparam int TARGET_LIMIT = 300;

	// Register reset values
	localparam logic signed [TARGET_W-1:0] TARGET_RST = 10'sd0;
	localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd512;
	localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd256;
	localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 2'd0,
		REG_PROP   = 2'd1,
		REG_INTEG  = 2'd2,
		REG_DERIV  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TARGET_W-1:0] target;
		logic signed [GAIN_W-1:0]   prop_gain;
		logic signed [GAIN_W-1:0]   integ_gain;
		logic signed [GAIN_W-1:0]   deriv_gain;
	} cfg_t;

endpackage

`default_nettype wire

// ===== design/encpid_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module encpid_cfg (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [encpid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [encpid_pkg::CFG_DATA_W-1:0]     cfg_data,
	output encpid_pkg::cfg_t                           cfg
);

	encpid_pkg::cfg_t cfg_q;
	logic signed [encpid_pkg::TARGET_W-1:0] tgt_raw;
	logic signed [encpid_pkg::TARGET_W-1:0] tgt_clamped;

	assign cfg_ready = 1'b1;
	assign tgt_raw   = $signed(cfg_data[encpid_pkg::TARGET_W-1:0]);

	// The target is clamped once, on the way in.
	always_comb begin
		if (tgt_raw > encpid_pkg::TARGET_LIMIT) begin
			tgt_clamped = encpid_pkg::TARGET_W'(encpid_pkg::TARGET_LIMIT);
		end else if (tgt_raw < -encpid_pkg::TARGET_LIMIT) begin
			tgt_clamped = encpid_pkg::TARGET_W'(-encpid_pkg::TARGET_LIMIT);
		end else begin
			tgt_clamped = tgt_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target     <= encpid_pkg::TARGET_RST;
			cfg_q.prop_gain  <= encpid_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain <= encpid_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain <= encpid_pkg::DERIV_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (encpid_pkg::cfg_idx_t'(cfg_index))
				encpid_pkg::REG_TARGET: cfg_q.target     <= tgt_clamped;
				encpid_pkg::REG_PROP:   cfg_q.prop_gain  <= $signed(cfg_data);
				encpid_pkg::REG_INTEG:  cfg_q.integ_gain <= $signed(cfg_data);
				encpid_pkg::REG_DERIV:  cfg_q.deriv_gain <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		($signed(cfg_q.target) <= encpid_pkg::TARGET_LIMIT)
		&& ($signed(cfg_q.target) >= -encpid_pkg::TARGET_LIMIT))
		else $error("target register outside its clamp range");

endmodule

`default_nettype wire

// ===== design/encpid_speed.sv =====
`timescale 1ns / 1ps
`default_nettype none

module encpid_speed (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic [encpid_pkg::COUNT_BITS-1:0]        in_count,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic signed [encpid_pkg::SPEED_W-1:0]         out_speed
);

	logic [encpid_pkg::COUNT_BITS-1:0]   prev_count_q;
	logic [encpid_pkg::COUNT_BITS-1:0]   dlt;
	logic [encpid_pkg::SPEED_MAG_W-1:0]  dext;
	logic [encpid_pkg::SPEED_MAG_W-1:0]  mag_c;
	logic [encpid_pkg::SPEED_PROD_W-1:0] prod_c;
	logic [encpid_pkg::SPEED_W-1:0]      mag_ext;

	logic                                v_s1, v_s2, v_s3;
	logic                                rdy1, rdy2, rdy3;
	logic                                ld1, ld2, ld3;
	logic [encpid_pkg::SPEED_MAG_W-1:0]  mag_s1;
	logic                                neg_s1, neg_s2;
	logic [encpid_pkg::SPEED_QMAG_W-1:0] mag_s2;
	logic signed [encpid_pkg::SPEED_W-1:0] speed_s3;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign ld1  = rdy1 && in_valid;
	assign ld2  = rdy2 && v_s1;
	assign ld3  = rdy3 && v_s2;

	// The counter difference wraps, so a rollover reads as the short path.
	assign dlt   = in_count - prev_count_q;
	assign dext  = {dlt[encpid_pkg::COUNT_BITS-1], dlt};
	assign mag_c = dlt[encpid_pkg::COUNT_BITS-1] ? (encpid_pkg::SPEED_MAG_W'(0) - dext) : dext;

	assign prod_c  = encpid_pkg::SPEED_PROD_W'(mag_s1)
		* encpid_pkg::SPEED_PROD_W'(encpid_pkg::SPEED_RECIP);
	assign mag_ext = {1'b0, mag_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			prev_count_q <= '0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (ld1) prev_count_q <= in_count;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			mag_s1 <= mag_c;
			neg_s1 <= dlt[encpid_pkg::COUNT_BITS-1];
		end
		if (ld2) begin
			mag_s2 <= prod_c[encpid_pkg::SPEED_SHIFT +: encpid_pkg::SPEED_QMAG_W];
			neg_s2 <= neg_s1;
		end
		if (ld3) begin
			speed_s3 <= neg_s2 ? -$signed(mag_ext) : $signed(mag_ext);
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s3;
	assign out_speed = speed_s3;

endmodule

`default_nettype wire

// ===== design/encpid_pid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module encpid_pid (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire encpid_pkg::cfg_t                     cfg,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [encpid_pkg::SPEED_W-1:0] in_speed,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [encpid_pkg::DRIVE_W-1:0]     out_drive,
	output logic [encpid_pkg::DUTY_W-1:0]             out_duty,
	output logic signed [encpid_pkg::SPEED_W-1:0]     out_speed
);

	// Controller state
	logic signed [encpid_pkg::INTEG_W-1:0] integ_q;
	logic signed [encpid_pkg::DIFF_W-1:0]  prev_err_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic ld1, ld2, ld3, ld4, ld5;

	// Stage 1: error
	logic signed [encpid_pkg::ERR_W-1:0]   tgt_q8;
	logic signed [encpid_pkg::ERR_W-1:0]   err_c;
	logic signed [encpid_pkg::ERR_W-1:0]   err_s1;
	logic signed [encpid_pkg::SPEED_W-1:0] spd_s1;

	// Stage 2: error / 20 and the derivative term
	logic [encpid_pkg::ERR_W-1:0]          err_abs;
	logic [encpid_pkg::QTR_W-1:0]          qtr;
	logic [encpid_pkg::DIV5_PROD_W-1:0]    div5_prod;
	logic signed [encpid_pkg::DIFF_W-1:0]  diff_c;
	logic signed [encpid_pkg::DERIV_W-1:0] diff_ext;
	logic [encpid_pkg::STEP_MAG_W-1:0]     qmag_s2;
	logic                                  qneg_s2;
	logic signed [encpid_pkg::ERR_W-1:0]   err_s2;
	logic signed [encpid_pkg::DERIV_W-1:0] deriv_s2;
	logic signed [encpid_pkg::SPEED_W-1:0] spd_s2;

	// Stage 3: integral
	logic signed [encpid_pkg::STEP_MAG_W:0]  step;
	logic signed [encpid_pkg::INTEG_W:0]     integ_sum;
	logic signed [encpid_pkg::INTEG_W-1:0]   integ_sat;
	logic signed [encpid_pkg::INTEG_W-1:0]   integ_s3;
	logic signed [encpid_pkg::ERR_W-1:0]     err_s3;
	logic signed [encpid_pkg::DERIV_W-1:0]   deriv_s3;
	logic signed [encpid_pkg::SPEED_W-1:0]   spd_s3;

	// Stage 4: gain products
	logic signed [encpid_pkg::PROP_PROD_W-1:0]  pp_c, pp_s4;
	logic signed [encpid_pkg::INTEG_PROD_W-1:0] ip_c, ip_s4;
	logic signed [encpid_pkg::DERIV_PROD_W-1:0] dp_c, dp_s4;
	logic signed [encpid_pkg::SPEED_W-1:0]      spd_s4;

	// Stage 5: drive
	logic signed [encpid_pkg::SUM_W-1:0]     sum_c;
	logic [encpid_pkg::SUM_W-1:0]            bias;
	logic signed [encpid_pkg::SUM_W-1:0]     biased;
	logic signed [encpid_pkg::DRIVE_Q_W-1:0] drive_int;
	logic signed [encpid_pkg::DRIVE_W-1:0]   drive_c;
	logic [encpid_pkg::DUTY_W-1:0]           duty_c;
	logic signed [encpid_pkg::DRIVE_W-1:0]   drive_s5;
	logic [encpid_pkg::DUTY_W-1:0]           duty_s5;
	logic signed [encpid_pkg::SPEED_W-1:0]   spd_s5;

	assign rdy5 = !v_s5 || out_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign ld1  = rdy1 && in_valid;
	assign ld2  = rdy2 && v_s1;
	assign ld3  = rdy3 && v_s2;
	assign ld4  = rdy4 && v_s3;
	assign ld5  = rdy5 && v_s4;

	assign tgt_q8 = encpid_pkg::ERR_W'($signed(cfg.target)) <<< encpid_pkg::FRAC_BITS;
	assign err_c  = tgt_q8 - encpid_pkg::ERR_W'(in_speed);

	// Truncating division by 20: drop two bits, then divide by five with a
	// rounded-up reciprocal that is exact over the whole error range.
	assign err_abs   = err_s1[encpid_pkg::ERR_W-1] ? $unsigned(-err_s1) : $unsigned(err_s1);
	assign qtr       = err_abs[encpid_pkg::ERR_MAG_W-1:2];
	assign div5_prod = encpid_pkg::DIV5_PROD_W'(qtr)
		* encpid_pkg::DIV5_PROD_W'(encpid_pkg::DIV5_RECIP);
	assign diff_c    = encpid_pkg::DIFF_W'(err_s1) - prev_err_q;
	assign diff_ext  = encpid_pkg::DERIV_W'(diff_c);

	assign step      = qneg_s2 ? -$signed({1'b0, qmag_s2}) : $signed({1'b0, qmag_s2});
	assign integ_sum = (encpid_pkg::INTEG_W + 1)'(integ_q)
		+ (encpid_pkg::INTEG_W + 1)'(step);

	// Saturate when the two top bits of the widened sum disagree.
	always_comb begin
		if (integ_sum[encpid_pkg::INTEG_W] != integ_sum[encpid_pkg::INTEG_W-1]) begin
			integ_sat = integ_sum[encpid_pkg::INTEG_W]
				? {1'b1, {(encpid_pkg::INTEG_W-1){1'b0}}}
				: {1'b0, {(encpid_pkg::INTEG_W-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[encpid_pkg::INTEG_W-1:0];
		end
	end

	assign pp_c = cfg.prop_gain * err_s3;
	assign ip_c = cfg.integ_gain * integ_s3;
	assign dp_c = cfg.deriv_gain * deriv_s3;

	// The sum is truncated toward zero: negative sums get a bias before the shift.
	assign sum_c = encpid_pkg::SUM_W'(pp_s4) + encpid_pkg::SUM_W'(ip_s4)
		+ encpid_pkg::SUM_W'(dp_s4);
	assign bias = sum_c[encpid_pkg::SUM_W-1]
		? encpid_pkg::SUM_W'((64'd1 << encpid_pkg::DRIVE_SHIFT) - 64'd1) : '0;
	assign biased    = sum_c + $signed(bias);
	assign drive_int = $signed(biased[encpid_pkg::SUM_W-1:encpid_pkg::DRIVE_SHIFT]);

	always_comb begin
		if (drive_int > encpid_pkg::DRIVE_LIMIT) begin
			drive_c = encpid_pkg::DRIVE_W'(encpid_pkg::DRIVE_LIMIT);
		end else if (drive_int < -encpid_pkg::DRIVE_LIMIT) begin
			drive_c = encpid_pkg::DRIVE_W'(-encpid_pkg::DRIVE_LIMIT);
		end else begin
			drive_c = drive_int[encpid_pkg::DRIVE_W-1:0];
		end
	end

	assign duty_c = $unsigned(drive_c) + encpid_pkg::DUTY_W'(encpid_pkg::DRIVE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			integ_q    <= '0;
			prev_err_q <= '0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (ld2) prev_err_q <= encpid_pkg::DIFF_W'(err_s1);
			if (ld3) integ_q <= integ_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			err_s1 <= err_c;
			spd_s1 <= in_speed;
		end
		if (ld2) begin
			qmag_s2  <= div5_prod[encpid_pkg::DIV5_SHIFT +: encpid_pkg::STEP_MAG_W];
			qneg_s2  <= err_s1[encpid_pkg::ERR_W-1];
			err_s2   <= err_s1;
			deriv_s2 <= (diff_ext <<< 4) + (diff_ext <<< 2);
			spd_s2   <= spd_s1;
		end
		if (ld3) begin
			integ_s3 <= integ_sat;
			err_s3   <= err_s2;
			deriv_s3 <= deriv_s2;
			spd_s3   <= spd_s2;
		end
		if (ld4) begin
			pp_s4  <= pp_c;
			ip_s4  <= ip_c;
			dp_s4  <= dp_c;
			spd_s4 <= spd_s3;
		end
		if (ld5) begin
			drive_s5 <= drive_c;
			duty_s5  <= duty_c;
			spd_s5   <= spd_s4;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s5;
	assign out_drive = drive_s5;
	assign out_duty  = duty_s5;
	assign out_speed = spd_s5;

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_drive <= encpid_pkg::DRIVE_LIMIT)
		&& (out_drive >= -encpid_pkg::DRIVE_LIMIT))
		else $error("drive beat outside the clamp range");

	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ld3 |=> $stable(integ_q))
		else $error("integral moved without a sample entering its stage");

	a_prev_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ld2 |=> $stable(prev_err_q))
		else $error("previous error moved without a sample entering its stage");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input blocked while the result side is not stalled");

endmodule

`default_nettype wire

// ===== design/encoder_pid_speed_control.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PID speed controller for a motor with a quadrature encoder. Each input beat is one
// sample tick (50 ms) carrying the raw 16-bit encoder count; each tick yields exactly one
// output beat with the clamped drive (-500..500), the PWM duty (drive + 500) and the
// measured speed in Q8 rpm. A new tick may be presented on every clock; three stages
// form the speed from the count difference, then five stages run the controller.
// The rate is one tick per clock while the output is not stalled, set by the
// combinational add-and-saturate of the integral. The gains and target must be
// written through the cfg port only while no tick is in flight; the block itself
// does not enforce this. The target is clamped to +-300 rpm as it is written.
// The first tick after reset is measured against a count of zero.
module encoder_pid_speed_control (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [15:0]                           s_axis_tdata,  // [15:0] encoder_count
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [9:0] drive_level, [19:10] duty_cycle, [45:20] measured_speed, [47:46] zero
	output logic [47:0]                                m_axis_tdata,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [encpid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [encpid_pkg::CFG_DATA_W-1:0]     cfg_data
);

	encpid_pkg::cfg_t cfg;

	logic                                   spd_valid;
	logic                                   spd_ready;
	logic signed [encpid_pkg::SPEED_W-1:0]  spd;
	logic signed [encpid_pkg::DRIVE_W-1:0]  drive_level;
	logic [encpid_pkg::DUTY_W-1:0]          duty_cycle;
	logic signed [encpid_pkg::SPEED_W-1:0]  measured_speed;

	encpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	encpid_speed u_speed (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_count  (s_axis_tdata[encpid_pkg::COUNT_BITS-1:0]),
		.out_valid (spd_valid),
		.out_ready (spd_ready),
		.out_speed (spd)
	);

	encpid_pid u_pid (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (spd_valid),
		.in_ready  (spd_ready),
		.in_speed  (spd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_drive (drive_level),
		.out_duty  (duty_cycle),
		.out_speed (measured_speed)
	);

	assign m_axis_tdata = {2'b00, measured_speed, duty_cycle, drive_level};

endmodule

`default_nettype wire
